/* src/bresenham_line_rasterizer_assert.svh */
// Assertion helpers shared by the rasterizer modules.
// Every macro samples on the rising edge of clk_i and is quiet while rst_ni is low.
`ifndef BRESENHAM_LINE_RASTERIZER_ASSERT_SVH
`define BRESENHAM_LINE_RASTERIZER_ASSERT_SVH

// Property that must hold at every sampled edge.
`define BLR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BLR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/blr_pkg.sv */
`default_nettype none

package blr_pkg;

  localparam int COORD_BITS = 12;
  localparam int REG_BITS   = 11;
  localparam int TEXT_BITS  = 16;
  localparam int TWICE_BITS = COORD_BITS + 1;
  localparam int ERR_BITS   = COORD_BITS + 3;
  localparam int CMP_BITS   = (COORD_BITS > REG_BITS) ? COORD_BITS : REG_BITS;

  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_WIDTH  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_HEIGHT = CFG_IDX_BITS'(1);
  localparam logic [REG_BITS-1:0] SCREEN_WIDTH_RST  = REG_BITS'(240);
  localparam logic [REG_BITS-1:0] SCREEN_HEIGHT_RST = REG_BITS'(120);

  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // A classified request: line setup is already worked out for starts.
  typedef struct packed {
    logic                  is_start;
    coord_t                x1;
    coord_t                y1;
    coord_t                x2;
    coord_t                y2;
    logic [TEXT_BITS-1:0]  glyph;
    logic [TEXT_BITS-1:0]  attr;
    logic [TWICE_BITS-1:0] twice_minor;
    logic [ERR_BITS-1:0]   err_init;
    logic [ERR_BITS-1:0]   err_diff;
    logic                  step_x_neg;
    logic                  step_y_neg;
    logic                  x_is_major;
    logic                  single;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef struct packed {
    logic                 valid_res;
    coord_t               x;
    coord_t               y;
    logic                 in_view;
    logic [TEXT_BITS-1:0] glyph;
    logic [TEXT_BITS-1:0] attr;
    logic                 last;
  } result_t;

endpackage

`default_nettype wire

/* src/blr_front.sv */
`default_nettype none

module blr_front (
  input  logic                          cmd_i,
  input  blr_pkg::coord_t               start_x_i,
  input  blr_pkg::coord_t               start_y_i,
  input  blr_pkg::coord_t               end_x_i,
  input  blr_pkg::coord_t               end_y_i,
  input  logic [blr_pkg::TEXT_BITS-1:0] glyph_i,
  input  logic [blr_pkg::TEXT_BITS-1:0] attr_i,
  output blr_pkg::entry_t               entry_o
);
  import blr_pkg::*;

  logic [COORD_BITS:0]   dx_pos, dx_neg, dy_pos, dy_neg;
  logic                  sxn, syn, xmaj;
  logic [COORD_BITS-1:0] mag_x, mag_y, major, minor;
  logic [ERR_BITS-1:0]   major_e, minor_e;

  // Both signed differences are formed in parallel; the sign picks the magnitude.
  assign dx_pos = {end_x_i[COORD_BITS-1], end_x_i} - {start_x_i[COORD_BITS-1], start_x_i};
  assign dx_neg = {start_x_i[COORD_BITS-1], start_x_i} - {end_x_i[COORD_BITS-1], end_x_i};
  assign dy_pos = {end_y_i[COORD_BITS-1], end_y_i} - {start_y_i[COORD_BITS-1], start_y_i};
  assign dy_neg = {start_y_i[COORD_BITS-1], start_y_i} - {end_y_i[COORD_BITS-1], end_y_i};

  // A coordinate that does not move counts as stepping negative.
  assign sxn = dx_pos[COORD_BITS] || (dx_pos == '0);
  assign syn = dy_pos[COORD_BITS] || (dy_pos == '0);

  assign mag_x = sxn ? dx_neg[COORD_BITS-1:0] : dx_pos[COORD_BITS-1:0];
  assign mag_y = syn ? dy_neg[COORD_BITS-1:0] : dy_pos[COORD_BITS-1:0];
  assign xmaj  = (mag_x >= mag_y);
  assign major = xmaj ? mag_x : mag_y;
  assign minor = xmaj ? mag_y : mag_x;

  assign major_e = ERR_BITS'(major);
  assign minor_e = ERR_BITS'(minor);

  always_comb begin
    entry_o             = '0;
    entry_o.is_start    = (cmd_i == CMD_START);
    entry_o.x1          = start_x_i;
    entry_o.y1          = start_y_i;
    entry_o.x2          = end_x_i;
    entry_o.y2          = end_y_i;
    entry_o.glyph       = glyph_i;
    entry_o.attr        = attr_i;
    entry_o.twice_minor = {minor, 1'b0};
    entry_o.err_init    = (minor_e << 1) - major_e;
    entry_o.err_diff    = (minor_e << 1) - (major_e << 1);
    entry_o.step_x_neg  = sxn;
    entry_o.step_y_neg  = syn;
    entry_o.x_is_major  = xmaj;
    entry_o.single      = xmaj ? (start_x_i == end_x_i) : (start_y_i == end_y_i);
  end

endmodule

`default_nettype wire

/* src/blr_queue.sv */
`default_nettype none

module blr_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  blr_pkg::entry_t        entry_i,
  input  logic                   pop_i,
  output blr_pkg::entry_t        entry_o,
  output blr_pkg::queue_status_t status_o
);
  import blr_pkg::*;

  entry_t                slots_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_BITS-1:0]  count_q, count_d;

  function automatic logic [QPTR_BITS-1:0] next_ptr(input logic [QPTR_BITS-1:0] p);
    return (p == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_BITS'(1);
  endfunction

  assign entry_o        = slots_q[rd_ptr_q];
  assign status_o.full  = (count_q == QCNT_BITS'(QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);

  always_comb begin
    wr_ptr_d = push_i ? next_ptr(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? next_ptr(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + QCNT_BITS'(push_i) - QCNT_BITS'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

`include "bresenham_line_rasterizer_assert.svh"

  `BLR_ASSERT(a_count_bound, count_q <= QCNT_BITS'(QUEUE_DEPTH), "queue count overflow")
  `BLR_ASSERT(a_no_push_full, push_i |-> !status_o.full, "request pushed into full queue")
  `BLR_ASSERT(a_no_pop_empty, pop_i |-> !status_o.empty, "request popped from empty queue")

endmodule

`default_nettype wire

/* src/blr_back.sv */
`default_nettype none

module blr_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  blr_pkg::entry_t              head_i,
  input  blr_pkg::queue_status_t       q_status_i,
  input  logic [blr_pkg::REG_BITS-1:0] screen_width_i,
  input  logic [blr_pkg::REG_BITS-1:0] screen_height_i,
  input  logic                         out_stall_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  output blr_pkg::result_t             res_o
);
  import blr_pkg::*;

  coord_t                cur_x_q, cur_y_q, stop_x_q, stop_y_q;
  logic [TWICE_BITS-1:0] twice_minor_q;
  logic [ERR_BITS-1:0]   err_diff_q, err_q;
  logic                  sxn_q, syn_q, xmaj_q;
  logic [TEXT_BITS-1:0]  glyph_q, attr_q;
  logic                  active_q, active_d;
  logic                  out_valid_q, out_valid_d;
  result_t               res_q, res_d;

  logic                  err_pos, mv_x, mv_y, fin_adv;
  coord_t                nx, ny, pt_x, pt_y;
  logic [ERR_BITS-1:0]   ne;

  function automatic logic visible(input coord_t x, input coord_t y,
                                   input logic [REG_BITS-1:0] w,
                                   input logic [REG_BITS-1:0] h);
    logic [CMP_BITS-1:0] xu, yu, wu, hu;
    xu = CMP_BITS'($unsigned(x));
    yu = CMP_BITS'($unsigned(y));
    wu = CMP_BITS'(w);
    hu = CMP_BITS'(h);
    return !x[COORD_BITS-1] && !y[COORD_BITS-1] && (xu < wu) && (yu < hu);
  endfunction

  // The output register is free when empty or when its point is being taken.
  assign pop_o       = !q_status_i.empty && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  // One Bresenham step from the held state.
  always_comb begin
    err_pos = !err_q[ERR_BITS-1];
    mv_x    = xmaj_q || err_pos;
    mv_y    = !xmaj_q || err_pos;
    nx      = mv_x ? (sxn_q ? cur_x_q - coord_t'(1) : cur_x_q + coord_t'(1)) : cur_x_q;
    ny      = mv_y ? (syn_q ? cur_y_q - coord_t'(1) : cur_y_q + coord_t'(1)) : cur_y_q;
    ne      = err_q + (err_pos ? err_diff_q : ERR_BITS'(twice_minor_q));
    fin_adv = xmaj_q ? (nx == stop_x_q) : (ny == stop_y_q);
  end

  always_comb begin
    pt_x     = head_i.is_start ? head_i.x1 : nx;
    pt_y     = head_i.is_start ? head_i.y1 : ny;
    active_d = active_q;
    res_d    = '0;
    if (head_i.is_start) begin
      active_d        = !head_i.single;
      res_d.valid_res = 1'b1;
      res_d.x         = pt_x;
      res_d.y         = pt_y;
      res_d.in_view   = visible(pt_x, pt_y, screen_width_i, screen_height_i);
      res_d.glyph     = head_i.glyph;
      res_d.attr      = head_i.attr;
      res_d.last      = head_i.single;
    end else if (active_q) begin
      active_d        = !fin_adv;
      res_d.valid_res = 1'b1;
      res_d.x         = pt_x;
      res_d.y         = pt_y;
      res_d.in_view   = visible(pt_x, pt_y, screen_width_i, screen_height_i);
      res_d.glyph     = glyph_q;
      res_d.attr      = attr_q;
      res_d.last      = fin_adv;
    end
  end

  always_comb begin
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        active_q <= active_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
      if (head_i.is_start) begin
        cur_x_q       <= head_i.x1;
        cur_y_q       <= head_i.y1;
        stop_x_q      <= head_i.x2;
        stop_y_q      <= head_i.y2;
        twice_minor_q <= head_i.twice_minor;
        err_diff_q    <= head_i.err_diff;
        err_q         <= head_i.err_init;
        sxn_q         <= head_i.step_x_neg;
        syn_q         <= head_i.step_y_neg;
        xmaj_q        <= head_i.x_is_major;
        glyph_q       <= head_i.glyph;
        attr_q        <= head_i.attr;
      end else if (active_q) begin
        cur_x_q <= nx;
        cur_y_q <= ny;
        err_q   <= ne;
      end
    end
  end

`include "bresenham_line_rasterizer_assert.svh"

  `BLR_ASSERT(a_last_ends_line, (out_valid_q && res_q.last) |-> !active_q,
              "line still active after its last point")
  `BLR_ASSERT(a_idle_result, (out_valid_q && !res_q.valid_res) |-> !active_q,
              "empty result while a line is running")
  `BLR_ASSERT_NEXT(a_single_point, pop_o && head_i.is_start && head_i.single, !active_q,
                   "single-point line left the block active")

endmodule

`default_nettype wire

/* src/bresenham_line_rasterizer.sv */
// Chan  Handshake                Fields
// in    in_valid_i/in_stall_o    cmd, start_x/y, end_x/y, glyph, attr
// out   out_valid_o/out_stall_i  valid_res, pix_x/y, in_view, glyph_out, attr_out, last
// cfg   cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
// While not stalled, one request is accepted and one point leaves per cycle; a request
// passes a queue slot and then the output register, which holds its point.
// The rate is set by the back end's step unit, which finishes one point per cycle.
// Reset is asynchronous and active low; it empties the queue, drops any line and
// restores the screen size to 240 by 120. Config writes are always ready.
// A stalled output holds its point; the two-entry queue then fills and stalls input.
`default_nettype none

module bresenham_line_rasterizer (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             cmd_i,
  input  blr_pkg::coord_t                  start_x_i,
  input  blr_pkg::coord_t                  start_y_i,
  input  blr_pkg::coord_t                  end_x_i,
  input  blr_pkg::coord_t                  end_y_i,
  input  logic [blr_pkg::TEXT_BITS-1:0]    glyph_i,
  input  logic [blr_pkg::TEXT_BITS-1:0]    attr_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             valid_res_o,
  output blr_pkg::coord_t                  pix_x_o,
  output blr_pkg::coord_t                  pix_y_o,
  output logic                             in_view_o,
  output logic [blr_pkg::TEXT_BITS-1:0]    glyph_out_o,
  output logic [blr_pkg::TEXT_BITS-1:0]    attr_out_o,
  output logic                             last_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [blr_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [blr_pkg::REG_BITS-1:0]     cfg_data_i
);
  import blr_pkg::*;

  logic [REG_BITS-1:0] screen_width_q, screen_width_d;
  logic [REG_BITS-1:0] screen_height_q, screen_height_d;
  entry_t              front_entry, head_entry;
  queue_status_t       q_status;
  logic                push, pop;
  result_t             res;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_status.full;
  assign push        = in_valid_i && !in_stall_o;

  always_comb begin
    screen_width_d  = screen_width_q;
    screen_height_d = screen_height_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SCREEN_WIDTH:  screen_width_d  = cfg_data_i;
        CFG_SCREEN_HEIGHT: screen_height_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_width_q  <= SCREEN_WIDTH_RST;
      screen_height_q <= SCREEN_HEIGHT_RST;
    end else begin
      screen_width_q  <= screen_width_d;
      screen_height_q <= screen_height_d;
    end
  end

  blr_front u_front (
    .cmd_i     (cmd_i),
    .start_x_i (start_x_i),
    .start_y_i (start_y_i),
    .end_x_i   (end_x_i),
    .end_y_i   (end_y_i),
    .glyph_i   (glyph_i),
    .attr_i    (attr_i),
    .entry_o   (front_entry)
  );

  blr_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (front_entry),
    .pop_i    (pop),
    .entry_o  (head_entry),
    .status_o (q_status)
  );

  blr_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head_entry),
    .q_status_i      (q_status),
    .screen_width_i  (screen_width_q),
    .screen_height_i (screen_height_q),
    .out_stall_i     (out_stall_i),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .res_o           (res)
  );

  assign valid_res_o = res.valid_res;
  assign pix_x_o     = res.x;
  assign pix_y_o     = res.y;
  assign in_view_o   = res.in_view;
  assign glyph_out_o = res.glyph;
  assign attr_out_o  = res.attr;
  assign last_o      = res.last;

endmodule

`default_nettype wire
